// ===== src/lpwm_pkg.sv =====
`timescale 1ns / 1ps

package lpwm_pkg;

    localparam int LANES   = 16;
    localparam int LEVEL_W = 8;
    localparam int CH_W    = 6;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_COMMIT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic                chip_number;
        logic [LEVEL_W-1:0]  slot_number;
        logic                frame_end;
    } t_beat_info;

endpackage

// ===== src/led_pwm_slice_frame_generator_top.sv =====
`timescale 1ns / 1ps

// PWM frame generator for a chain of 16-channel LED driver chips.
// The input channel (i_in_valid / o_in_ready) takes one beat per cycle while o_in_ready is
// high: a color write into the back picture, a commit, or a read of the next shift word.
// Only a read produces a beat on the output channel (o_out_valid / i_out_ready).
// Each chip owns one row per picture in sixteen lane memories, so a whole shift word is
// fetched in one read and compared against the slot in parallel.
// A read beat passes the fetch stage and then the output register before it appears at
// the output; the block sustains one input beat per clock while the receiver keeps up.
// The output register and the fetch stage form a two-deep pipeline: when the
// receiver stalls, one more read can be fetched before o_in_ready drops.
// At reset the configured slot count returns to 255, the front picture is the
// first one, and the level memories are cleared one row per cycle, all 2 * CHIP_COUNT
// rows, while o_in_ready stays low.
// Slot count writes on i_cfg_we are taken at any time and need no handshake.

module led_pwm_slice_frame_generator_top import lpwm_pkg::*; #(
    parameter int CHIP_COUNT = 2,
    parameter int LED_COUNT  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_led_index,
    input  logic [7:0]         i_blue_level,
    input  logic [7:0]         i_red_level,
    input  logic [7:0]         i_green_level,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_shift_word,
    output logic               o_chip_number,
    output logic [7:0]         o_slot_number,
    output logic               o_frame_end
);

    localparam int ROWS     = 2 * CHIP_COUNT;
    localparam int ADDR_W   = $clog2(ROWS);
    localparam int CHIP_W   = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
    localparam int CHANNELS = CHIP_COUNT * LANES;

    logic               r_front;
    logic               r_pending;
    logic [LEVEL_W-1:0] r_slot_pos;
    logic [CHIP_W-1:0]  r_chip_pos;
    logic [LEVEL_W-1:0] r_slot_count;
    logic               r_clr_active;
    logic [ADDR_W-1:0]  r_clr_row;
    logic               r_s1_valid;
    t_beat_info         r_s1_info;

    logic               n_front;
    logic               n_pending;
    logic [LEVEL_W-1:0] n_slot_pos;
    logic [CHIP_W-1:0]  n_chip_pos;
    logic               n_s1_valid;

    logic               w_take;
    logic               w_accept;
    logic               w_read;
    logic               w_write;
    logic               w_last_chip;
    logic               w_end;
    logic [CHIP_W-1:0]  w_chip_read;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_led_ok;
    logic [CH_W-1:0]    w_ch [3];
    logic [LEVEL_W-1:0] w_level [3];
    logic               w_ch_ok [3];
    logic [ADDR_W-1:0]  w_ch_row [3];
    logic               w_lane_we [LANES];
    logic [ADDR_W-1:0]  w_lane_waddr [LANES];
    logic [LEVEL_W-1:0] w_lane_wdata [LANES];
    logic [LANES-1:0]   w_hits;

    assign o_in_ready = !r_clr_active && (!r_s1_valid || w_take);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_read     = w_accept && (i_func == FUNC_READ);
    assign w_write    = w_accept && (i_func == FUNC_WRITE);

    assign w_last_chip = (r_chip_pos == CHIP_W'(CHIP_COUNT - 1));
    assign w_end       = w_last_chip && (r_slot_pos >= r_slot_count);
    assign w_chip_read = CHIP_W'(CHIP_COUNT - 1) - r_chip_pos;
    assign w_raddr     = ADDR_W'({w_chip_read, r_front});

    assign w_led_ok   = ({4'b0, i_led_index} < 8'(LED_COUNT));
    assign w_level[0] = i_blue_level;
    assign w_level[1] = i_red_level;
    assign w_level[2] = i_green_level;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_ch[j]     = CH_W'({i_led_index, 1'b0}) + CH_W'(i_led_index) + CH_W'(j);
            w_ch_ok[j]  = w_led_ok && ({3'b0, w_ch[j]} < 9'(CHANNELS));
            w_ch_row[j] = ADDR_W'({5'(w_ch[j][CH_W-1:4]), !r_front});
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_lane_we[l]    = 1'b0;
            w_lane_waddr[l] = r_clr_row;
            w_lane_wdata[l] = '0;
            if (r_clr_active) begin
                w_lane_we[l] = 1'b1;
            end else begin
                for (int j = 0; j < 3; j++) begin
                    if (w_write && w_ch_ok[j] && (w_ch[j][3:0] == 4'(l))) begin
                        w_lane_we[l]    = 1'b1;
                        w_lane_waddr[l] = w_ch_row[j];
                        w_lane_wdata[l] = w_level[j];
                    end
                end
            end
        end
    end

    always_comb begin
        n_front    = r_front;
        n_pending  = r_pending;
        n_slot_pos = r_slot_pos;
        n_chip_pos = r_chip_pos;
        if (w_accept) begin
            case (i_func)
                FUNC_WRITE: begin
                    n_pending = 1'b0;
                end
                FUNC_COMMIT: begin
                    n_pending = 1'b1;
                end
                FUNC_READ: begin
                    if (w_last_chip) begin
                        n_chip_pos = '0;
                        if (w_end) begin
                            n_slot_pos = 8'd1;
                            if (r_pending) begin
                                n_front   = !r_front;
                                n_pending = 1'b0;
                            end
                        end else begin
                            n_slot_pos = r_slot_pos + 8'd1;
                        end
                    end else begin
                        n_chip_pos = r_chip_pos + CHIP_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_read) begin
            n_s1_valid = 1'b1;
        end else if (w_take) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front      <= 1'b0;
            r_pending    <= 1'b0;
            r_slot_pos   <= 8'd1;
            r_chip_pos   <= '0;
            r_slot_count <= 8'd255;
            r_clr_active <= 1'b1;
            r_clr_row    <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_front    <= n_front;
            r_pending  <= n_pending;
            r_slot_pos <= n_slot_pos;
            r_chip_pos <= n_chip_pos;
            r_s1_valid <= n_s1_valid;
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_data;
            end
            if (r_clr_active) begin
                r_clr_row <= r_clr_row + ADDR_W'(1);
                if (r_clr_row == ADDR_W'(ROWS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_s1_info.chip_number <= w_chip_read[0];
            r_s1_info.slot_number <= r_slot_pos;
            r_s1_info.frame_end   <= w_end;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        lpwm_lane #(
            .ROWS   (ROWS),
            .ADDR_W (ADDR_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (w_lane_we[l]),
            .i_waddr (w_lane_waddr[l]),
            .i_wdata (w_lane_wdata[l]),
            .i_re    (w_read),
            .i_raddr (w_raddr),
            .i_slot  (r_s1_info.slot_number),
            .o_hit   (w_hits[l])
        );
    end

    lpwm_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s1_valid),
        .i_hits        (w_hits),
        .i_info        (r_s1_info),
        .o_take        (w_take),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_shift_word  (o_shift_word),
        .o_chip_number (o_chip_number),
        .o_slot_number (o_slot_number),
        .o_frame_end   (o_frame_end)
    );

    a_read_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read |=> r_s1_valid)
        else $error("accepted read did not reach the fetch stage");

    a_frame_end_chip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_chip_number == 1'b0))
        else $error("frame ended on a chip other than chip zero");

    a_chip_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chip_pos <= CHIP_W'(CHIP_COUNT - 1))
        else $error("chip position out of range");

    a_swap_on_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front != $past(r_front)) |-> $past(w_read && w_end && r_pending))
        else $error("picture swapped outside a committed frame end");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |=> !r_s1_valid)
        else $error("read fetched during the clearing pass");

endmodule

// ===== src/lpwm_lane.sv =====
`timescale 1ns / 1ps

module lpwm_lane import lpwm_pkg::*; #(
    parameter int ROWS   = 4,
    parameter int ADDR_W = 2
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [LEVEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    input  logic [LEVEL_W-1:0] i_slot,
    output logic               o_hit
);

    logic [LEVEL_W-1:0] r_mem [ROWS];
    logic [LEVEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_hit = (r_rdata >= i_slot);

endmodule

// ===== src/lpwm_merge.sv =====
`timescale 1ns / 1ps

module lpwm_merge import lpwm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [LANES-1:0]   i_hits,
    input  t_beat_info         i_info,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LANES-1:0]   o_shift_word,
    output logic               o_chip_number,
    output logic [LEVEL_W-1:0] o_slot_number,
    output logic               o_frame_end
);

    logic             r_valid;
    logic [LANES-1:0] r_word;
    t_beat_info       r_info;

    assign o_take = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_word <= i_hits;
            r_info <= i_info;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_shift_word  = r_word;
    assign o_chip_number = r_info.chip_number;
    assign o_slot_number = r_info.slot_number;
    assign o_frame_end   = r_info.frame_end;

endmodule
